@@ hdl/tstc_pkg.sv @@
// shared types and constants for the timespec / timestamp converter
// no dependencies; used by tstc_finish, the top level and the checkers

package tstc_pkg;

    localparam int SECONDS_BITS_DEF = 64;
    localparam int DIV_STEPS        = 8;
    localparam int UNITS_W          = 30;
    localparam int WORD_W           = 64;
    localparam int NPT_NUM_W        = 32;

    localparam logic [UNITS_W-1:0] NS_PER_SEC = 30'd1000000000;

    // pipeline depth: input stage, two dividers, two finishing stages
    localparam int DIVA_STAGES = (NPT_NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIVB_STAGES = (WORD_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int LATENCY     = 1 + DIVA_STAGES + DIVB_STAGES + 2;

    // register indexes
    localparam logic REG_EPOCH = 1'b0;
    localparam logic REG_UNITS = 1'b1;

    // operation codes
    localparam logic OP_TO_TS   = 1'b0;
    localparam logic OP_TO_PAIR = 1'b1;

    // carried alongside the nanoseconds-per-tick divider
    typedef struct packed {
        logic              op;
        logic              neg;
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] sec;
    } t_side_a;

    // carried alongside the main divider
    typedef struct packed {
        logic               op;
        logic               neg;
        logic [WORD_W-1:0]  sec;
        logic [UNITS_W-1:0] npt;
    } t_side_b;

endpackage

@@ hdl/tstc_div_pipe.sv @@
// pipelined restoring divider, STEPS quotient bits per stage, with sideband
// depends on nothing outside this file

module tstc_div_pipe #(
    parameter int N      = 64,
    parameter int D      = 30,
    parameter int STEPS  = 8,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [N-1:0]      i_num,
    input  logic [D-1:0]      i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [N-1:0]      o_quo,
    output logic [D-1:0]      o_rem,
    output logic [SIDE_W-1:0] o_side
);

    localparam int STAGES = (N + STEPS - 1) / STEPS;

    logic              r_valid [STAGES];
    logic [D-1:0]      r_rem   [STAGES];
    logic [N-1:0]      r_quo   [STAGES];
    logic [D-1:0]      r_den   [STAGES];
    logic [SIDE_W-1:0] r_side  [STAGES];

    logic              w_valid [STAGES+1];
    logic [D-1:0]      w_rem   [STAGES+1];
    logic [N-1:0]      w_quo   [STAGES+1];
    logic [D-1:0]      w_den   [STAGES+1];
    logic [SIDE_W-1:0] w_side  [STAGES+1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = '0;
    assign w_quo[0]   = i_num;
    assign w_den[0]   = i_den;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic [D-1:0] n_rem;
        logic [N-1:0] n_quo;
        logic [D:0]   c_shift;
        logic [D+1:0] c_diff;

        // one group of shift and trial subtract steps
        always_comb begin
            n_rem   = w_rem[g];
            n_quo   = w_quo[g];
            c_shift = '0;
            c_diff  = '0;
            for (int k = 0; k < STEPS; k++) begin
                if (g * STEPS + k < N) begin
                    c_shift = {n_rem, n_quo[N-1]};
                    c_diff  = {1'b0, c_shift} - {2'b00, w_den[g]};
                    if (!c_diff[D+1]) begin
                        n_rem = c_diff[D-1:0];
                        n_quo = {n_quo[N-2:0], 1'b1};
                    end else begin
                        n_rem = c_shift[D-1:0];
                        n_quo = {n_quo[N-2:0], 1'b0};
                    end
                end
            end
        end

        // stage register
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= w_valid[g];
            end
            r_rem[g]  <= n_rem;
            r_quo[g]  <= n_quo;
            r_den[g]  <= w_den[g];
            r_side[g] <= w_side[g];
        end

        assign w_valid[g+1] = r_valid[g];
        assign w_rem[g+1]   = r_rem[g];
        assign w_quo[g+1]   = r_quo[g];
        assign w_den[g+1]   = r_den[g];
        assign w_side[g+1]  = r_side[g];
    end

    assign o_valid = w_valid[STAGES];
    assign o_quo   = w_quo[STAGES];
    assign o_rem   = w_rem[STAGES];
    assign o_side  = w_side[STAGES];

endmodule

@@ hdl/tstc_finish.sv @@
// final two stages: scaling products, sign and borrow fixes, range check
// depends on tstc_pkg

module tstc_finish #(
    parameter int SECONDS_BITS = tstc_pkg::SECONDS_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [tstc_pkg::WORD_W-1:0]       i_quo,
    input  logic [tstc_pkg::UNITS_W-1:0]      i_rem,
    input  tstc_pkg::t_side_b                 i_side,
    input  logic [tstc_pkg::UNITS_W-1:0]      i_units,
    input  logic [tstc_pkg::WORD_W-1:0]       i_epoch,
    output logic                              o_valid,
    output logic signed [tstc_pkg::WORD_W-1:0] o_out_timestamp,
    output logic signed [tstc_pkg::WORD_W-1:0] o_out_seconds,
    output logic [tstc_pkg::UNITS_W-1:0]      o_out_nanoseconds,
    output logic                              o_status
);

    localparam int W = tstc_pkg::WORD_W;
    localparam int U = tstc_pkg::UNITS_W;

    // stage one registers
    logic           r_v1;
    logic           r_op1;
    logic [61:0]    r_lo;
    logic [31:0]    r_hi;
    logic [W-1:0]   r_q;
    logic [W:0]     r_whole;
    logic           r_remnz;

    logic [31:0]    c_ma;
    logic [U-1:0]   c_mb;
    logic [61:0]    n_lo;
    logic [61:0]    n_hi;
    logic [W-1:0]   n_q;
    logic [W:0]     n_whole;

    // one multiplier shared by both directions, one for the upper seconds half
    always_comb begin
        c_ma    = (i_side.op == tstc_pkg::OP_TO_PAIR) ? {2'b00, i_rem} : i_side.sec[31:0];
        c_mb    = (i_side.op == tstc_pkg::OP_TO_PAIR) ? i_side.npt : i_units;
        n_lo    = c_ma * c_mb;
        n_hi    = i_side.sec[63:32] * i_units;
        n_q     = i_side.neg ? (~i_quo + 1'b1) : i_quo;
        n_whole = i_side.neg ? (~{1'b0, i_quo} + 1'b1) : {1'b0, i_quo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_op1   <= i_side.op;
        r_lo    <= n_lo;
        r_hi    <= n_hi[31:0];
        r_q     <= n_q;
        r_whole <= n_whole;
        r_remnz <= i_side.neg && (i_rem != '0);
    end

    // stage two: timestamp sum, or borrow and range check
    logic [W-1:0]   c_ts;
    logic [W:0]     c_whole;
    logic [U-1:0]   c_ns;
    logic [W-SECONDS_BITS+1:0] c_top;
    logic           c_oor;

    always_comb begin
        c_ts    = {2'b00, r_lo} + {r_hi, 32'd0} + r_q + i_epoch;
        c_whole = r_remnz ? (r_whole - 1'b1) : r_whole;
        c_ns    = r_remnz ? (tstc_pkg::NS_PER_SEC - r_lo[U-1:0]) : r_lo[U-1:0];
        c_top   = c_whole[W:SECONDS_BITS-1];
        c_oor   = !((&c_top) || !(|c_top));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v1;
        end
        if (r_op1 == tstc_pkg::OP_TO_TS) begin
            o_out_timestamp   <= c_ts;
            o_out_seconds     <= '0;
            o_out_nanoseconds <= '0;
            o_status          <= 1'b0;
        end else begin
            o_out_timestamp   <= '0;
            o_out_seconds     <= c_oor ? '0 : c_whole[W-1:0];
            o_out_nanoseconds <= c_oor ? '0 : c_ns;
            o_status          <= c_oor;
        end
    end

endmodule

@@ hdl/timespec_timestamp_converter.sv @@
// top level of the timespec / timestamp converter
// depends on tstc_pkg, tstc_div_pipe and tstc_finish
//
// Usage: a transaction enters when i_start is high while o_busy is low; o_busy
// is never raised, so one transaction can enter in every clock cycle.
// i_operation 0 turns seconds plus nanoseconds into a scaled timestamp,
// 1 turns a timestamp back into seconds and normalized nanoseconds.
// Each result appears on the output ports for one cycle with o_valid high,
// in the order the transactions entered.
// The pipeline has one input stage, a 4-stage divider for the
// nanoseconds per tick, an 8-stage 64-bit divider (8 quotient bits per stage)
// and two finishing stages with the scaling multipliers and final adder.
// Throughput is one transaction per cycle.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 epoch offset, 1 units per second) at once; write only while no
// transaction is in flight.
// Reset (synchronous, active low) empties the pipeline and restores the
// registers to epoch 0 and one billion units per second.
// The receiver cannot stall: every result is shown once and must be taken.

module timespec_timestamp_converter #(
    parameter int SECONDS_BITS = tstc_pkg::SECONDS_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [tstc_pkg::WORD_W-1:0]        i_cfg_data,
    input  logic                               i_operation,
    input  logic signed [63:0]                 i_in_seconds,
    input  logic signed [30:0]                 i_in_nanoseconds,
    input  logic signed [63:0]                 i_in_timestamp,
    output logic                               o_valid,
    output logic signed [63:0]                 o_out_timestamp,
    output logic signed [63:0]                 o_out_seconds,
    output logic [29:0]                        o_out_nanoseconds,
    output logic                               o_status
);

    localparam int W = tstc_pkg::WORD_W;
    localparam int U = tstc_pkg::UNITS_W;

    assign o_busy = 1'b0;

    // configuration registers, units stored already clamped
    logic [W-1:0] r_epoch;
    logic [U-1:0] r_units;
    logic [U-1:0] c_units_wr;

    always_comb begin
        c_units_wr = i_cfg_data[U-1:0];
        if (c_units_wr == '0) begin
            c_units_wr = U'(1);
        end else if (c_units_wr > tstc_pkg::NS_PER_SEC) begin
            c_units_wr = tstc_pkg::NS_PER_SEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= '0;
            r_units <= tstc_pkg::NS_PER_SEC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tstc_pkg::REG_EPOCH: r_epoch <= i_cfg_data;
                tstc_pkg::REG_UNITS: r_units <= c_units_wr;
                default:             r_epoch <= r_epoch;
            endcase
        end
    end

    // input stage: borrow, epoch removal, sign and magnitude
    logic              r_v0;
    tstc_pkg::t_side_a r_sa;
    tstc_pkg::t_side_a n_sa;
    logic signed [31:0] c_ns;
    logic [W-1:0]      c_t;

    always_comb begin
        c_ns   = 32'(i_in_nanoseconds);
        n_sa.op = i_operation;
        n_sa.sec = i_in_seconds;
        if (i_in_nanoseconds < 0) begin
            c_ns     = c_ns + $signed({2'b00, tstc_pkg::NS_PER_SEC});
            n_sa.sec = i_in_seconds - 64'd1;
        end
        c_t = i_in_timestamp - r_epoch;
        if (i_operation == tstc_pkg::OP_TO_TS) begin
            n_sa.neg = c_ns[31];
            n_sa.mag = {32'd0, (c_ns[31] ? (-c_ns) : c_ns)};
        end else begin
            n_sa.neg = c_t[W-1];
            n_sa.mag = c_t[W-1] ? (~c_t + 1'b1) : c_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_start && !o_busy;
        end
        r_sa <= n_sa;
    end

    // nanoseconds per tick: one billion over the units
    logic              w_va;
    logic [tstc_pkg::NPT_NUM_W-1:0] w_npt_quo;
    logic [U-1:0]      w_npt_rem;
    tstc_pkg::t_side_a w_sa;

    tstc_div_pipe #(
        .N      (tstc_pkg::NPT_NUM_W),
        .D      (U),
        .STEPS  (tstc_pkg::DIV_STEPS),
        .SIDE_W ($bits(tstc_pkg::t_side_a))
    ) u_div_npt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_num   ({2'b00, tstc_pkg::NS_PER_SEC}),
        .i_den   (r_units),
        .i_side  (r_sa),
        .o_valid (w_va),
        .o_quo   (w_npt_quo),
        .o_rem   (w_npt_rem),
        .o_side  (w_sa)
    );

    // main divider: nanoseconds over ns per tick, or timestamp over units
    tstc_pkg::t_side_b c_sb;
    logic [U-1:0]      c_den;
    logic              w_vb;
    logic [W-1:0]      w_quo;
    logic [U-1:0]      w_rem;
    tstc_pkg::t_side_b w_sb;

    always_comb begin
        c_sb.op  = w_sa.op;
        c_sb.neg = w_sa.neg;
        c_sb.sec = w_sa.sec;
        c_sb.npt = w_npt_quo[U-1:0] | (w_npt_rem & '0);
        c_den    = (w_sa.op == tstc_pkg::OP_TO_PAIR) ? r_units : w_npt_quo[U-1:0];
    end

    tstc_div_pipe #(
        .N      (W),
        .D      (U),
        .STEPS  (tstc_pkg::DIV_STEPS),
        .SIDE_W ($bits(tstc_pkg::t_side_b))
    ) u_div_main (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_va),
        .i_num   (w_sa.mag),
        .i_den   (c_den),
        .i_side  (c_sb),
        .o_valid (w_vb),
        .o_quo   (w_quo),
        .o_rem   (w_rem),
        .o_side  (w_sb)
    );

    tstc_finish #(
        .SECONDS_BITS (SECONDS_BITS)
    ) u_finish (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_vb),
        .i_quo             (w_quo),
        .i_rem             (w_rem),
        .i_side            (w_sb),
        .i_units           (r_units),
        .i_epoch           (r_epoch),
        .o_valid           (o_valid),
        .o_out_timestamp   (o_out_timestamp),
        .o_out_seconds     (o_out_seconds),
        .o_out_nanoseconds (o_out_nanoseconds),
        .o_status          (o_status)
    );

endmodule

@@ hdl/tstc_checker.sv @@
// port-level checks for the timespec / timestamp converter, bound to the top
// depends on tstc_pkg and timespec_timestamp_converter

module tstc_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_valid,
    input logic signed [63:0] o_out_timestamp,
    input logic signed [63:0] o_out_seconds,
    input logic [29:0]        o_out_nanoseconds,
    input logic               o_status
);

    localparam int LAT = tstc_pkg::LATENCY;

    // every accepted transaction yields a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_valid)
        else $error("missing result after accepted transaction");

    // no result without a transaction that latency earlier
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##LAT !o_valid)
        else $error("result without transaction");

    // range error clears the pair
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_out_seconds == 64'sd0 && o_out_nanoseconds == 30'd0
                                   && o_out_timestamp == 64'sd0))
        else $error("range error with nonzero fields");

    // nanoseconds stay normalized
    a_ns_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_nanoseconds < 30'd1000000000))
        else $error("nanoseconds out of range");

endmodule

bind timespec_timestamp_converter tstc_port_checks u_tstc_port_checks (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .o_busy            (o_busy),
    .o_valid           (o_valid),
    .o_out_timestamp   (o_out_timestamp),
    .o_out_seconds     (o_out_seconds),
    .o_out_nanoseconds (o_out_nanoseconds),
    .o_status          (o_status)
);

@@ tb/tstc_checker.sv @@
// result checker for the timespec / timestamp converter
// depends on tstc_pkg; watches the transaction and result ports of the block

module tstc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_operation,
    input  logic [63:0] i_in_seconds,
    input  logic [30:0] i_in_nanoseconds,
    input  logic [63:0] i_in_timestamp,
    input  logic        i_valid,
    input  logic [63:0] i_out_timestamp,
    input  logic [63:0] i_out_seconds,
    input  logic [29:0] i_out_nanoseconds,
    input  logic        i_status,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [63:0] stamp;
        logic [63:0] secs;
        logic [29:0] nsec;
        logic        status;
    } t_conv;

    logic [63:0] epoch_q;
    logic [29:0] units_q;
    t_conv       conv_q[$];

    assign o_pending = conv_q.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        o_errors++;
    endtask

    // conversion in either direction, full-width signed arithmetic
    function automatic t_conv convert(input logic op, input logic [63:0] sec,
                                      input logic [30:0] ns_in, input logic [63:0] ts);
        t_conv r;
        longint u, npt, s, n, t, whole, rem, ep;
        r = '0;
        ep = epoch_q;
        u = units_q;
        if (u == 0) u = 1;
        if (u > 1000000000) u = 1000000000;
        npt = 1000000000 / u;
        if (op == tstc_pkg::OP_TO_TS) begin
            s = sec;
            n = longint'($signed(ns_in));
            if (n < 0) begin
                s = s - 1;
                n = n + 1000000000;
            end
            r.stamp = s * u + n / npt + ep;
        end else begin
            t = ts - ep;
            whole = t / u;
            rem = t - whole * u;
            n = rem * npt;
            if (n < 0) begin
                whole = whole - 1;
                n = n + 1000000000;
            end
            // 64-bit seconds range never overflows here
            r.secs = whole;
            r.nsec = n[29:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_conv got, want;
        if (!i_rst_n) begin
            epoch_q <= '0;
            units_q <= 30'd1000000000;
            conv_q.delete();
        end else begin
            if (i_valid) begin
                got = {i_out_timestamp, i_out_seconds, i_out_nanoseconds, i_status};
                if (conv_q.size() == 0) begin
                    report_mismatch("unexpected result", got.stamp, 0);
                end else begin
                    want = conv_q.pop_front();
                    if (got.stamp !== want.stamp)
                        report_mismatch("timestamp", got.stamp, want.stamp);
                    if (got.secs !== want.secs)
                        report_mismatch("seconds", got.secs, want.secs);
                    if (got.nsec !== want.nsec)
                        report_mismatch("nanoseconds", got.nsec, want.nsec);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
            // predict from the current settings before any write lands
            if (i_start && !i_busy)
                conv_q.push_back(convert(i_operation, i_in_seconds, i_in_nanoseconds,
                                         i_in_timestamp));
            if (i_cfg_we) begin
                if (i_cfg_index == tstc_pkg::REG_EPOCH) epoch_q <= i_cfg_data;
                else units_q <= i_cfg_data[29:0];
            end
        end
    end

    initial o_errors = 0;
endmodule

@@ tb/tb.sv @@
// testbench top for the timespec / timestamp converter
// depends on tstc_pkg, timespec_timestamp_converter and tstc_checker

module tb;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 0, rst_n = 0, start = 0, cfg_we = 0;
    logic        cfg_index = tstc_pkg::REG_EPOCH;
    logic [63:0] cfg_data = '0;
    logic        operation = tstc_pkg::OP_TO_TS;
    logic [63:0] in_seconds = '0, in_timestamp = '0;
    logic [30:0] in_nanoseconds = '0;
    logic        busy, valid, status;
    logic [63:0] out_timestamp, out_seconds;
    logic [29:0] out_nanoseconds;
    int          errors, pending, cycles = 0;
    logic        idle_on = 1;

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    timespec_timestamp_converter DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_operation(operation), .i_in_seconds(in_seconds),
        .i_in_nanoseconds(in_nanoseconds), .i_in_timestamp(in_timestamp),
        .o_valid(valid), .o_out_timestamp(out_timestamp), .o_out_seconds(out_seconds),
        .o_out_nanoseconds(out_nanoseconds), .o_status(status)
    );

    tstc_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_operation(operation), .i_in_seconds(in_seconds),
        .i_in_nanoseconds(in_nanoseconds), .i_in_timestamp(in_timestamp),
        .i_valid(valid), .i_out_timestamp(out_timestamp), .i_out_seconds(out_seconds),
        .i_out_nanoseconds(out_nanoseconds), .i_status(status),
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** timespec_timestamp_converter: FAILED **");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one transaction, sometimes with a random idle burst ahead of it
    task automatic send(input logic op, input logic [63:0] sec, input logic [30:0] ns,
                        input logic [63:0] ts);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        start <= 1;
        operation <= op;
        in_seconds <= sec;
        in_nanoseconds <= ns;
        in_timestamp <= ts;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 0;
        while (pending != 0) @(negedge clk);
        repeat (tstc_pkg::LATENCY + 2) @(negedge clk);
    endtask

    // one register write; cfg_we is dropped again before the task returns
    task automatic write_reg(input logic idx, input logic [63:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    // random seconds near zero mostly, full range sometimes
    function automatic logic [63:0] rand_secs();
        if ($urandom_range(0, 3) == 0) return rand64();
        return 64'($signed($urandom_range(0, 4000000)) - 2000000);
    endfunction

    function automatic logic [30:0] rand_ns();
        unique case ($urandom_range(0, 5))
            0: return 31'($urandom);
            1: return -31'($urandom_range(1, 999999999));
            default: return 31'($urandom_range(0, 999999999));
        endcase
    endfunction

    initial begin
        logic [63:0] unit_set[8] = '{64'd1000000000, 64'd1, 64'd0, 64'h3FFF_FFFF,
                                     64'd1000, 64'd7, 64'd1000000, 64'd3};
        logic [63:0] epoch_set[4] = '{64'd0, 64'h7FFF_FFFF_FFFF_FFFF,
                                      64'h8000_0000_0000_0000, 64'd0};
        logic [63:0] max_s, min_s;
        max_s = 64'h7FFF_FFFF_FFFF_FFFF;
        min_s = 64'h8000_0000_0000_0000;
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed extremes at reset settings, then with 7 units and epoch 12345
        send(tstc_pkg::OP_TO_TS, 0, 0, 0);
        send(tstc_pkg::OP_TO_TS, max_s, 31'd999999999, 0);
        send(tstc_pkg::OP_TO_TS, min_s, -31'd999999999, 0);
        send(tstc_pkg::OP_TO_TS, 5, -31'd1, 0);
        send(tstc_pkg::OP_TO_TS, 1, 31'h3FFF_FFFF, 0);
        send(tstc_pkg::OP_TO_TS, 1, 31'h4000_0000, 0);
        send(tstc_pkg::OP_TO_PAIR, 0, 0, max_s);
        send(tstc_pkg::OP_TO_PAIR, 0, 0, min_s);
        send(tstc_pkg::OP_TO_PAIR, 0, 0, -64'd1);
        send(tstc_pkg::OP_TO_PAIR, 0, 0, 64'd1999999999);
        send(tstc_pkg::OP_TO_PAIR, 0, 0, -64'd1000000001);
        drain();
        write_reg(tstc_pkg::REG_UNITS, 64'd7);
        write_reg(tstc_pkg::REG_EPOCH, 64'd12345);
        send(tstc_pkg::OP_TO_PAIR, 0, 0, min_s);
        send(tstc_pkg::OP_TO_PAIR, 0, 0, max_s);
        send(tstc_pkg::OP_TO_PAIR, 0, 0, -64'd3);
        send(tstc_pkg::OP_TO_TS, -64'd1, -31'd999999999, 0);
        send(tstc_pkg::OP_TO_TS, max_s, 31'd500000000, 0);
        drain();

        // random phases across settings
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(tstc_pkg::REG_UNITS,
                      ph < 8 ? unit_set[ph] : 64'($urandom_range(0, 1 << 30)));
            write_reg(tstc_pkg::REG_EPOCH, ph < 4 ? epoch_set[ph] : rand64());
            idle_on = (ph < 13);
            for (int k = 0; k < 88; k++) begin
                if ($urandom_range(0, 1))
                    send(tstc_pkg::OP_TO_TS, rand_secs(), rand_ns(), rand64());
                else
                    send(tstc_pkg::OP_TO_PAIR, rand64(), 31'($urandom),
                         $urandom_range(0, 3) == 0 ? rand64() :
                         cfg_data + 64'($signed($urandom) >>> $urandom_range(0, 31)));
            end
            drain();
        end

        if (errors == 0) begin
            $display("** timespec_timestamp_converter: PASSED **");
        end else begin
            $display("** timespec_timestamp_converter: FAILED **");
        end
        $finish;
    end
endmodule
